// ===== hdl/oiq_pkg.sv =====
// ----------------------------------------------------------------------------
// oiq_pkg
// Shared types and codes for the ordered insert queue.
// ----------------------------------------------------------------------------
package oiq_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	// operation codes
	localparam logic [1:0] FUNC_APPEND  = 2'd0;
	localparam logic [1:0] FUNC_ORDERED = 2'd1;
	localparam logic [1:0] FUNC_REMOVE  = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic [1:0]         status;
		logic [4:0]         occupancy;
	} out_item_t;

	// broadcast to every cell; at most one strobe is high
	typedef struct packed {
		logic               do_append;
		logic               do_insert;
		logic               do_remove;
		logic signed [31:0] value;
	} cell_ctrl_t;

endpackage

// ===== hdl/oiq_cell.sv =====
// ----------------------------------------------------------------------------
// oiq_cell
// One slot of the queue: holds an entry, compares it with the broadcast
// value and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module oiq_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned CNT_W = 5
) (
	input  logic               clk,
	input  oiq_pkg::cell_ctrl_t ctrl,
	input  logic [CNT_W-1:0]   count,
	input  logic signed [31:0] left_entry,
	input  logic               left_gt,
	input  logic signed [31:0] right_entry,
	output logic signed [31:0] entry,
	output logic               gt
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic signed [31:0] entry_q;
	logic               occ;

	assign occ   = count > IDX_C;
	// high while every cell up to here holds a greater entry; the first
	// cell where it drops is the insert point, everything after it shifts
	assign gt    = left_gt && occ && (entry_q > ctrl.value);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.do_append) begin
			if (count == IDX_C)
				entry_q <= ctrl.value;
		end else if (ctrl.do_insert) begin
			if (!gt) begin
				if (left_gt)
					entry_q <= ctrl.value;
				else
					entry_q <= left_entry;
			end
		end else if (ctrl.do_remove) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hdl/ordered_insert_queue_top.sv =====
// ----------------------------------------------------------------------------
// ordered_insert_queue_top
// Bounded queue of signed values with append, ordered insert and remove
// front, built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Result: valid in the cycle after the request is accepted.
// Throughput: one request per cycle while no result waits on out_ready; every
// cell compares and shifts in parallel, so an ordered insert costs as an append.
// Reset: entry count and output valid clear asynchronously; stored entries
// are left as they are and only slots below the count are ever read.
module ordered_insert_queue_top #(
	parameter int unsigned DEPTH = oiq_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  oiq_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output oiq_pkg::out_item_t out_data
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	logic                accept;
	logic                full;
	logic                empty;
	logic                is_ins;
	logic                is_rem;
	oiq_pkg::cell_ctrl_t ctrl;
	oiq_pkg::out_item_t  res;
	logic                out_valid_q;
	oiq_pkg::out_item_t  out_data_q;

	logic signed [31:0] entry [DEPTH];
	logic               gt    [DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = count_q == FULL_CNT;
	assign empty    = count_q == '0;
	assign is_ins   = (in_data.func == oiq_pkg::FUNC_APPEND) ||
	                  (in_data.func == oiq_pkg::FUNC_ORDERED);
	assign is_rem   = in_data.func == oiq_pkg::FUNC_REMOVE;

	always_comb begin
		ctrl.value     = in_data.value;
		ctrl.do_append = accept && !full && (in_data.func == oiq_pkg::FUNC_APPEND);
		ctrl.do_insert = accept && !full && (in_data.func == oiq_pkg::FUNC_ORDERED);
		ctrl.do_remove = accept && !empty && is_rem;
	end

	always_comb begin
		count_nxt = count_q;
		if (ctrl.do_append || ctrl.do_insert)
			count_nxt = count_q + CNT_W'(1);
		else if (ctrl.do_remove)
			count_nxt = count_q - CNT_W'(1);
	end

	always_comb begin
		res.removed_value = '0;
		res.status        = oiq_pkg::ST_DONE;
		res.occupancy     = 5'(count_nxt);
		if (is_ins && full)
			res.status = oiq_pkg::ST_FULL;
		else if (is_rem && empty)
			res.status = oiq_pkg::ST_EMPTY;
		else if (is_rem)
			res.removed_value = entry[0];
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic signed [31:0] l_entry;
			logic               l_gt;
			logic signed [31:0] r_entry;

			if (i == 0) begin : g_first
				assign l_entry = in_data.value;
				assign l_gt    = 1'b1;
			end else begin : g_mid
				assign l_entry = entry[i-1];
				assign l_gt    = gt[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign r_entry = entry[i];
			end else begin : g_inner
				assign r_entry = entry[i+1];
			end

			oiq_cell #(
				.IDX  (i),
				.CNT_W(CNT_W)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.count      (count_q),
				.left_entry (l_entry),
				.left_gt    (l_gt),
				.right_entry(r_entry),
				.entry      (entry[i]),
				.gt         (gt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (in_ready)
				out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hdl/oiq_checker.sv =====
// ----------------------------------------------------------------------------
// oiq_checker
// Port-level checks for the ordered insert queue, bound to the top level.
// ----------------------------------------------------------------------------
module oiq_checker #(
	parameter int unsigned DEPTH = oiq_pkg::DEPTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input oiq_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input oiq_pkg::out_item_t out_data
);

	localparam logic [4:0] FULL_OCC = 5'(DEPTH);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// every accepted request yields a result next cycle
	a_req_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request produced no result");

	a_empty_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == oiq_pkg::ST_EMPTY |->
		out_data.occupancy == 5'd0 && out_data.removed_value == 32'sd0)
		else $error("empty status with entries or value");

	a_full_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == oiq_pkg::ST_FULL |->
		out_data.occupancy == FULL_OCC && out_data.removed_value == 32'sd0)
		else $error("full status with wrong occupancy");

endmodule

bind ordered_insert_queue_top oiq_checker #(.DEPTH(DEPTH)) u_oiq_checker (.*);
